// ===== hw/rtl/tpzs_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the torus shader.
// No dependencies; every other file imports this package.
package tpzs_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 22;
    localparam int ANGLE_BITS = 10;
    localparam int DEPTH_BITS = 16;

    localparam int CELLS      = ROWS * COLUMNS;
    localparam int CELL_W     = 11;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int SHADE_W    = 4;
    localparam int MEM_W      = DEPTH_BITS + SHADE_W;

    localparam int FRAC_BITS  = 16;
    localparam longint ONE    = 65536;
    localparam int EYE_OFFSET = 5;
    localparam int RING_RADIUS = 3;
    localparam int INTENSITY  = 8;
    localparam int X_ORIGIN   = 40;
    localparam int Y_ORIGIN   = 12;
    localparam int X_GAIN     = 30;
    localparam int Y_GAIN     = 15;
    localparam int BLANK      = 12;
    localparam int TOP_SHADE  = 11;
    localparam int BR_SHIFT   = FRAC_BITS - $clog2(INTENSITY);

    // fixed point working width (Q16, values stay well below 2^22)
    localparam int Q_W        = 24;
    // divider: dividend up to 2^(DEPTH_BITS+16), divisor is the positive denominator
    localparam int DIV_W      = DEPTH_BITS + FRAC_BITS + 2;
    localparam int DEN_W      = Q_W;

    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W      = ANGLE_BITS - 1;
    localparam int SIN_W      = FRAC_BITS + 1;

    typedef logic signed [Q_W-1:0] t_q;
    typedef logic [ANGLE_BITS-1:0] t_angle;
    typedef logic [SIN_W-1:0] t_sin_tab [0:QUARTER];

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PLOT  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_PITCH = 2'd0,
        CFG_YAW   = 2'd1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TRIG,
        S_MUL,
        S_NUM,
        S_DIVGO,
        S_DIVWT,
        S_ADDR,
        S_RDA,
        S_RDB,
        S_DONE
    } t_state;

    // Q16 product truncated toward zero (elaboration only)
    function automatic longint qm(input longint a, input longint b);
        return (a * b) / ONE;
    endfunction

    // odd polynomial sine over a quarter turn, clamped to [0, 1.0]
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        longint t, t2, s;
        for (int i = 0; i <= QUARTER; i++) begin
            t  = longint'(i) * ONE / QUARTER;
            t2 = qm(t, t);
            s  = -307;
            s  = 5223 + qm(s, t2);
            s  = -42334 + qm(s, t2);
            s  = 102944 + qm(s, t2);
            s  = qm(s, t);
            if (s < 0) s = 0;
            if (s > ONE) s = ONE;
            tab[i] = SIN_W'(s);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

    // full-turn sine from the quarter table by quadrant folding
    function automatic t_q qsin(input t_angle p);
        logic [ANGLE_BITS-3:0] r;
        logic [IDX_W-1:0] idx;
        t_q s;
        r   = p[ANGLE_BITS-3:0];
        idx = p[ANGLE_BITS-2] ? (IDX_W'(QUARTER) - {1'b0, r}) : {1'b0, r};
        s   = Q_W'(SIN_TAB[idx]);
        return p[ANGLE_BITS-1] ? -s : s;
    endfunction

    function automatic t_q qcos(input t_angle p);
        return qsin(p + t_angle'(QUARTER));
    endfunction

endpackage

// ===== hw/rtl/torus_point_zbuffer_shader.sv =====
// Torus sample shader with character-cell z-buffer; uses tpzs_pkg, tpzs_qmul, tpzs_div.
// Plot: trig lookup, 16 Q16 products through the shared multiplier, three passes through one
//   bit-serial divider (column, row, depth), then the buffer read and conditional update.
// Read: registered buffer read; a cell outside the grid skips it. Clear: one cell per cycle.
// One transaction at a time; next accept after the output load, which i_stall may hold off.
// Reset (synchronous, active low) starts a sweep that blanks the buffer.
module torus_point_zbuffer_shader import tpzs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [ANGLE_BITS-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_action,
    input  logic [ANGLE_BITS-1:0] i_ring_angle,
    input  logic [ANGLE_BITS-1:0] i_tube_angle,
    input  logic [CELL_W-1:0]     i_read_cell,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CELL_W-1:0]     o_cell_res,
    output logic [SHADE_W-1:0]    o_shade,
    output logic                  o_updated
);

    localparam int MUL_STEPS = 16;
    localparam int STEP_W    = $clog2(MUL_STEPS);
    localparam logic [1:0] DSEL_COL   = 2'd0;
    localparam logic [1:0] DSEL_ROW   = 2'd1;
    localparam logic [1:0] DSEL_DEPTH = 2'd2;
    localparam logic [DEPTH_BITS-1:0] DMAX = '1;
    localparam logic signed [DIV_W-1:0] DEPTH_NUM = DIV_W'(1) <<< (DEPTH_BITS + FRAC_BITS);

    t_state r_state, n_state;

    // configuration and accepted transaction
    t_angle              r_pitch, r_yaw, r_ring, r_tube;
    logic [1:0]          r_act;
    logic [CELL_W-1:0]   r_cell;
    logic [CELL_W-1:0]   r_clr_cnt;
    logic                r_clr_report;

    // trig values and products
    t_q r_ct, r_st, r_cr, r_sr, r_cp, r_sp, r_cy, r_sy;
    t_q r_a, r_m1, r_m2, r_m3, r_m4, r_c, r_m6, r_m7;
    t_q r_m8, r_m9, r_e, r_m11, r_m12, r_m13, r_f, r_m15;
    logic [STEP_W-1:0] r_step;
    logic              r_phase;

    logic [DEN_W-1:0]          r_den;
    logic signed [DIV_W-1:0]   r_ncol, r_nrow, r_col, r_row;
    logic [SHADE_W-1:0]        r_br;
    logic [DEPTH_BITS-1:0]     r_dsat;
    logic [1:0]                r_dsel;

    // result hold and output register
    logic [CELL_W-1:0]  r_res_cell, r_o_cell;
    logic [SHADE_W-1:0] r_res_shade, r_o_shade;
    logic               r_res_upd, r_o_upd, r_ov;

    // buffer: {depth, shade} per cell
    logic [MEM_W-1:0]  r_mem [0:CELLS-1];
    logic [MEM_W-1:0]  r_rd;

    logic              w_accept, w_load;
    logic              w_mem_we;
    logic [CELL_W-1:0] w_mem_addr;
    logic [MEM_W-1:0]  w_mem_wdata;
    t_q                w_op_a, w_op_b, w_q, w_rad, w_y3;
    logic              w_div_start, w_div_done;
    logic signed [DIV_W-1:0] w_div_num, w_quo;
    logic              w_nearer;

    t_q w_den_raw, w_den_c, w_xp, w_yp, w_light, w_br_sh;
    logic signed [DIV_W-1:0] w_den_x;
    logic              w_on;
    logic [CELL_W-1:0] w_pos;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_DONE) && (!r_ov || !i_stall);
    assign w_rad    = r_cr + t_q'(RING_RADIUS * ONE);
    assign w_y3     = r_m3 - r_m4;
    assign w_nearer = (r_dsat > r_rd[MEM_W-1:SHADE_W]);

    // projection terms
    assign w_den_raw = r_m1 + r_m2 + t_q'(EYE_OFFSET * ONE);
    assign w_den_c   = (w_den_raw < t_q'(1)) ? t_q'(1) : w_den_raw;
    assign w_xp      = r_m6 - r_m7;
    assign w_yp      = r_m8 + r_m9;
    assign w_light   = r_m12 - r_m13 - r_m2 - r_m15;
    assign w_br_sh   = w_light >>> BR_SHIFT;
    assign w_den_x   = DIV_W'(w_den_c);

    // screen bounds and cell index
    assign w_on  = (r_row > 0) && (r_row < DIV_W'(ROWS)) &&
                   (r_col > 0) && (r_col < DIV_W'(COLUMNS));
    assign w_pos = CELL_W'(r_col[COL_W-1:0]) +
                   CELL_W'(COLUMNS) * CELL_W'(r_row[ROW_W-1:0]);

    tpzs_qmul u_qmul (
        .i_clk (i_clk),
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_p   (w_q)
    );

    tpzs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == CELL_W'(CELLS - 1)) n_state = r_clr_report ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_action)
                        ACT_CLEAR: n_state = S_CLEAR;
                        ACT_PLOT:  n_state = S_TRIG;
                        ACT_READ:  n_state = (i_read_cell < CELL_W'(CELLS)) ? S_RDA : S_DONE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_TRIG:  n_state = S_MUL;
            S_MUL: begin
                if (r_phase && r_step == STEP_W'(MUL_STEPS - 1)) n_state = S_NUM;
            end
            S_NUM:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIVWT;
            S_DIVWT: begin
                if (w_div_done) n_state = (r_dsel == DSEL_DEPTH) ? S_ADDR : S_DIVGO;
            end
            S_ADDR:  n_state = w_on ? S_RDA : S_DONE;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_DONE;
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // per-state outputs: memory port, multiplier operands, divider start
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_addr  = r_cell;
        w_mem_wdata = {r_dsat, r_br};
        w_div_start = 1'b0;
        w_op_a      = r_st;
        w_op_b      = w_rad;
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr_cnt;
                w_mem_wdata = {{DEPTH_BITS{1'b0}}, SHADE_W'(BLANK)};
            end
            S_RDB: begin
                w_mem_we = (r_act == ACT_PLOT) && w_nearer;
            end
            S_DIVGO: begin
                w_div_start = 1'b1;
            end
            S_MUL: begin
                case (r_step)
                    4'd0:  begin w_op_a = r_st;           w_op_b = w_rad; end
                    4'd1:  begin w_op_a = r_a;            w_op_b = r_sp;  end
                    4'd2:  begin w_op_a = r_sr;           w_op_b = r_cp;  end
                    4'd3:  begin w_op_a = r_a;            w_op_b = r_cp;  end
                    4'd4:  begin w_op_a = r_sr;           w_op_b = r_sp;  end
                    4'd5:  begin w_op_a = r_ct;           w_op_b = w_rad; end
                    4'd6:  begin w_op_a = r_c;            w_op_b = r_cy;  end
                    4'd7:  begin w_op_a = w_y3;           w_op_b = r_sy;  end
                    4'd8:  begin w_op_a = r_c;            w_op_b = r_sy;  end
                    4'd9:  begin w_op_a = w_y3;           w_op_b = r_cy;  end
                    4'd10: begin w_op_a = r_st;           w_op_b = r_cr;  end
                    4'd11: begin w_op_a = r_e;            w_op_b = r_cp;  end
                    4'd12: begin w_op_a = r_m4 - r_m11;   w_op_b = r_cy;  end
                    4'd13: begin w_op_a = r_e;            w_op_b = r_sp;  end
                    4'd14: begin w_op_a = r_ct;           w_op_b = r_cr;  end
                    4'd15: begin w_op_a = r_f;            w_op_b = r_sy;  end
                    default: begin w_op_a = r_st;         w_op_b = w_rad; end
                endcase
            end
            default: begin
            end
        endcase
    end

    // divider dividend select
    always_comb begin
        case (r_dsel)
            DSEL_COL: w_div_num = r_ncol;
            DSEL_ROW: w_div_num = r_nrow;
            default:  w_div_num = DEPTH_NUM;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_cnt    <= '0;
            r_clr_report <= 1'b0;
            r_pitch      <= '0;
            r_yaw        <= '0;
            r_ov         <= 1'b0;
            r_step       <= '0;
            r_phase      <= 1'b0;
            r_dsel       <= DSEL_COL;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PITCH: r_pitch <= i_cfg_wdata;
                    CFG_YAW:   r_yaw   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (w_load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (r_state == S_CLEAR) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (w_accept && i_action == ACT_CLEAR) begin
                r_clr_cnt    <= '0;
                r_clr_report <= 1'b1;
            end
            if (r_state == S_TRIG) begin
                r_step  <= '0;
                r_phase <= 1'b0;
            end
            if (r_state == S_MUL) begin
                r_phase <= ~r_phase;
                if (r_phase) r_step <= r_step + 1'b1;
            end
            if (r_state == S_NUM) r_dsel <= DSEL_COL;
            if (r_state == S_DIVWT && w_div_done) r_dsel <= r_dsel + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act       <= i_action;
            r_ring      <= i_ring_angle;
            r_tube      <= i_tube_angle;
            r_cell      <= i_read_cell;
            r_res_cell  <= (i_action == ACT_READ) ? i_read_cell : '0;
            r_res_shade <= SHADE_W'(BLANK);
            r_res_upd   <= 1'b0;
        end
        if (r_state == S_CLEAR) begin
            r_res_cell  <= '0;
            r_res_shade <= SHADE_W'(BLANK);
            r_res_upd   <= 1'b0;
        end
        if (r_state == S_TRIG) begin
            r_ct <= qcos(r_tube);
            r_st <= qsin(r_tube);
            r_cr <= qcos(r_ring);
            r_sr <= qsin(r_ring);
            r_cp <= qcos(r_pitch);
            r_sp <= qsin(r_pitch);
            r_cy <= qcos(r_yaw);
            r_sy <= qsin(r_yaw);
        end
        // capture the finished product of the current step
        if (r_state == S_MUL && r_phase) begin
            case (r_step)
                4'd0:  r_a   <= w_q;
                4'd1:  r_m1  <= w_q;
                4'd2:  r_m2  <= w_q;
                4'd3:  r_m3  <= w_q;
                4'd4:  r_m4  <= w_q;
                4'd5:  r_c   <= w_q;
                4'd6:  r_m6  <= w_q;
                4'd7:  r_m7  <= w_q;
                4'd8:  r_m8  <= w_q;
                4'd9:  r_m9  <= w_q;
                4'd10: r_e   <= w_q;
                4'd11: r_m11 <= w_q;
                4'd12: r_m12 <= w_q;
                4'd13: r_m13 <= w_q;
                4'd14: r_f   <= w_q;
                4'd15: r_m15 <= w_q;
                default: r_a <= w_q;
            endcase
        end
        if (r_state == S_NUM) begin
            r_den  <= w_den_c[DEN_W-1:0];
            r_ncol <= DIV_W'(X_ORIGIN) * w_den_x + DIV_W'(X_GAIN) * DIV_W'(w_xp);
            r_nrow <= DIV_W'(Y_ORIGIN) * w_den_x + DIV_W'(Y_GAIN) * DIV_W'(w_yp);
            if (w_light < 0) r_br <= '0;
            else if (w_br_sh > t_q'(TOP_SHADE)) r_br <= SHADE_W'(TOP_SHADE);
            else r_br <= w_br_sh[SHADE_W-1:0];
        end
        if (r_state == S_DIVWT && w_div_done) begin
            case (r_dsel)
                DSEL_COL: r_col <= w_quo;
                DSEL_ROW: r_row <= w_quo;
                default:  r_dsat <= (w_quo > DIV_W'(DMAX)) ? DMAX : w_quo[DEPTH_BITS-1:0];
            endcase
        end
        if (r_state == S_ADDR && w_on) begin
            r_cell     <= w_pos;
            r_res_cell <= w_pos;
        end
        if (r_state == S_RDB) begin
            if (r_act == ACT_PLOT && w_nearer) begin
                r_res_shade <= r_br;
                r_res_upd   <= 1'b1;
            end else begin
                r_res_shade <= r_rd[SHADE_W-1:0];
            end
        end
        if (w_load) begin
            r_o_cell  <= r_res_cell;
            r_o_shade <= r_res_shade;
            r_o_upd   <= r_res_upd;
        end
    end

    // cell buffer, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_addr] <= w_mem_wdata;
        r_rd <= r_mem[w_mem_addr];
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ov;
    assign o_cell_res = r_o_cell;
    assign o_shade    = r_o_shade;
    assign o_updated  = r_o_upd;

endmodule

// ===== hw/rtl/tpzs_qmul.sv =====
// Registered Q16 multiplier shared by the whole transform sequence.
// Depends on tpzs_pkg for the fixed-point width.
module tpzs_qmul import tpzs_pkg::*; (
    input  logic i_clk,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_p
);

    logic signed [2*Q_W-1:0] w_prod;
    logic signed [2*Q_W-1:0] w_adj;
    logic signed [2*Q_W-1:0] w_sh;
    t_q r_p;

    // truncate toward zero: bias negatives before the arithmetic shift
    assign w_prod = i_a * i_b;
    assign w_adj  = w_prod + (w_prod[2*Q_W-1] ? (2*Q_W)'(ONE - 1) : '0);
    assign w_sh   = w_adj >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_p <= w_sh[Q_W-1:0];
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/tpzs_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tpzs_pkg for widths; divisor is always positive.
module tpzs_div import tpzs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // restoring step: shift in next dividend bit, subtract when it fits
    assign w_sh   = {r_rem[DEN_W-1:0], r_quo[DIV_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num[DIV_W-1] ? DIV_W'(-i_num) : DIV_W'(i_num);
            r_neg <= i_num[DIV_W-1];
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_sh;
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule
